/* rtl/psb_pkg.sv */
// package: shared widths, command and status codes, result type, sequencer states
package psb_pkg;

	localparam int VAL_W = 32;
	localparam int CMD_W = 3;
	localparam int POS_W = 5;
	localparam int ST_W  = 2;
	localparam int LEN_W = 5;

	localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DUMP    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd6;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} psb_status_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		psb_status_t             status;
		logic [LEN_W-1:0]        length;
		logic                    last;
	} psb_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_WR,
		S_DN_RD,
		S_DN_WR,
		S_RV_RDA,
		S_RV_RDB,
		S_RV_WRA,
		S_RV_WRB,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_STATUS
	} psb_state_t;

endpackage

/* rtl/psb_cmd_if.sv */
// interface: command channel with valid/ready handshake
interface psb_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [psb_pkg::CMD_W-1:0]         cmd;
	logic signed [psb_pkg::VAL_W-1:0]  item_value;
	logic [psb_pkg::POS_W-1:0]         insert_position;

	modport source (output valid, cmd, item_value, insert_position, input ready);
	modport sink (input valid, cmd, item_value, insert_position, output ready);
endinterface

/* rtl/psb_res_if.sv */
// interface: result channel with valid/ready handshake
interface psb_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [psb_pkg::VAL_W-1:0]  out_value;
	logic [psb_pkg::ST_W-1:0]          status;
	logic [psb_pkg::LEN_W-1:0]         length;
	logic                              last;

	modport source (output valid, out_value, status, length, last, input ready);
	modport sink (input valid, out_value, status, length, last, output ready);
endinterface

/* rtl/positional_sequence_buffer.sv */
// top level: bounded ordered store with positional insert, reverse and dump
// sequencing: append, clear or a rejected command goes straight to its status beat; insert
// at position p first moves the cells from p to the tail up by one, remove head moves them down
// flow: not ready while a command runs; a dump reads one element at a time through the
// single ram read port feeding the output register, and waits while that register is full
// reset: clears the element count, the sequencer and the output beat; cells stay undefined
module positional_sequence_buffer #(
	parameter int CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	psb_cmd_if.sink    cmd_ch,
	psb_res_if.source  res_ch
);

	localparam int AW = $clog2(CAPACITY);

	logic                          slot_free;
	logic                          emit;
	psb_pkg::psb_res_t             res;
	psb_pkg::psb_res_t             out_q;
	logic                          out_vld_q;
	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [psb_pkg::VAL_W-1:0]     mem_wdata;
	logic [AW-1:0]                 mem_raddr;
	logic [psb_pkg::VAL_W-1:0]     mem_rdata;

	psb_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.slot_free (slot_free),
		.emit      (emit),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	psb_ram #(
		.WIDTH (psb_pkg::VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output beat register
	assign slot_free = !out_vld_q || res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign res_ch.valid     = out_vld_q;
	assign res_ch.out_value = out_q.value;
	assign res_ch.status    = out_q.status;
	assign res_ch.length    = out_q.length;
	assign res_ch.last      = out_q.last;

endmodule

/* rtl/psb_ram.sv */
// generic single write port ram with registered read
module psb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/psb_ctrl.sv */
// sequencer: command decode, element count, index unit and ram access steps
module psb_ctrl #(
	parameter int CAPACITY = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	psb_cmd_if.sink                        cmd_ch,
	input  logic                           slot_free,
	output logic                           emit,
	output psb_pkg::psb_res_t              res,
	output logic                           mem_we,
	output logic [$clog2(CAPACITY)-1:0]    mem_waddr,
	output logic [psb_pkg::VAL_W-1:0]      mem_wdata,
	output logic [$clog2(CAPACITY)-1:0]    mem_raddr,
	input  logic [psb_pkg::VAL_W-1:0]      mem_rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > psb_pkg::POS_W) ? CW : psb_pkg::POS_W;

	psb_pkg::psb_state_t   state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	logic [AW-1:0]         idx_q, idx_d;
	logic [AW-1:0]         jdx_q, jdx_d;
	logic [psb_pkg::VAL_W-1:0] val_q, val_d;
	psb_pkg::psb_status_t  st_q, st_d;

	logic [PW-1:0]         pos_ext;
	logic [PW-1:0]         cnt_ext;
	logic [CW-1:0]         cnt_m1;
	logic                  full;
	logic                  empty;
	logic                  accept;

	assign pos_ext = PW'(cmd_ch.insert_position);
	assign cnt_ext = PW'(count_q);
	assign cnt_m1  = count_q - CW'(1);
	assign full    = (count_q == CW'(CAPACITY));
	assign empty   = (count_q == '0);
	assign cmd_ch.ready = (state_q == psb_pkg::S_IDLE);
	assign accept  = cmd_ch.valid && cmd_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psb_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		jdx_q <= jdx_d;
		val_q <= val_d;
		st_q  <= st_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		jdx_d     = jdx_q;
		val_d     = val_q;
		st_d      = st_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_raddr = idx_q;
		emit      = 1'b0;
		res.value  = '0;
		res.status = st_q;
		res.length = cnt_ext[psb_pkg::LEN_W-1:0];
		res.last   = 1'b1;

		case (state_q)
			psb_pkg::S_IDLE: begin
				if (accept) begin
					st_d    = psb_pkg::ST_OK;
					state_d = psb_pkg::S_STATUS;
					val_d   = cmd_ch.item_value;
					case (cmd_ch.cmd)
						psb_pkg::CMD_APPEND: begin
							if (full) begin
								st_d = psb_pkg::ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = cmd_ch.item_value;
								count_d   = count_q + CW'(1);
							end
						end
						psb_pkg::CMD_PREPEND: begin
							if (full) begin
								st_d = psb_pkg::ST_FULL;
							end else begin
								idx_d   = count_q[AW-1:0];
								jdx_d   = '0;
								state_d = psb_pkg::S_UP_RD;
							end
						end
						psb_pkg::CMD_INSERT: begin
							if (pos_ext > cnt_ext) begin
								st_d = psb_pkg::ST_BADPOS;
							end else if (full) begin
								st_d = psb_pkg::ST_FULL;
							end else begin
								idx_d   = count_q[AW-1:0];
								jdx_d   = pos_ext[AW-1:0];
								state_d = psb_pkg::S_UP_RD;
							end
						end
						psb_pkg::CMD_REMOVE: begin
							if (!empty) begin
								idx_d   = '0;
								state_d = psb_pkg::S_DN_RD;
							end
						end
						psb_pkg::CMD_REVERSE: begin
							if (empty) begin
								st_d = psb_pkg::ST_EMPTY;
							end else begin
								idx_d   = '0;
								jdx_d   = cnt_m1[AW-1:0];
								state_d = psb_pkg::S_RV_RDA;
							end
						end
						psb_pkg::CMD_DUMP: begin
							if (empty) begin
								st_d = psb_pkg::ST_EMPTY;
							end else begin
								idx_d   = '0;
								state_d = psb_pkg::S_DUMP_RD;
							end
						end
						psb_pkg::CMD_CLEAR: begin
							count_d = '0;
						end
						default: begin
							st_d = psb_pkg::ST_BADPOS;
						end
					endcase
				end
			end

			// open a gap: move cells up from the tail down to the insert point
			psb_pkg::S_UP_RD: begin
				if (idx_q == jdx_q) begin
					mem_we    = 1'b1;
					mem_wdata = val_q;
					count_d   = count_q + CW'(1);
					state_d   = psb_pkg::S_STATUS;
				end else begin
					mem_raddr = idx_q - AW'(1);
					state_d   = psb_pkg::S_UP_WR;
				end
			end
			psb_pkg::S_UP_WR: begin
				mem_we  = 1'b1;
				idx_d   = idx_q - AW'(1);
				state_d = psb_pkg::S_UP_RD;
			end

			// close the head: move cells down by one
			psb_pkg::S_DN_RD: begin
				if (idx_q == cnt_m1[AW-1:0]) begin
					count_d = cnt_m1;
					state_d = psb_pkg::S_STATUS;
				end else begin
					mem_raddr = idx_q + AW'(1);
					state_d   = psb_pkg::S_DN_WR;
				end
			end
			psb_pkg::S_DN_WR: begin
				mem_we  = 1'b1;
				idx_d   = idx_q + AW'(1);
				state_d = psb_pkg::S_DN_RD;
			end

			// swap the outer pair and walk inward
			psb_pkg::S_RV_RDA: begin
				if (idx_q >= jdx_q) begin
					state_d = psb_pkg::S_STATUS;
				end else begin
					state_d = psb_pkg::S_RV_RDB;
				end
			end
			psb_pkg::S_RV_RDB: begin
				mem_raddr = jdx_q;
				val_d     = mem_rdata;
				state_d   = psb_pkg::S_RV_WRA;
			end
			psb_pkg::S_RV_WRA: begin
				mem_we  = 1'b1;
				state_d = psb_pkg::S_RV_WRB;
			end
			psb_pkg::S_RV_WRB: begin
				mem_we    = 1'b1;
				mem_waddr = jdx_q;
				mem_wdata = val_q;
				idx_d     = idx_q + AW'(1);
				jdx_d     = jdx_q - AW'(1);
				state_d   = psb_pkg::S_RV_RDA;
			end

			psb_pkg::S_DUMP_RD: begin
				state_d = psb_pkg::S_DUMP_OUT;
			end
			psb_pkg::S_DUMP_OUT: begin
				res.value  = mem_rdata;
				res.status = psb_pkg::ST_OK;
				res.last   = (idx_q == cnt_m1[AW-1:0]);
				if (slot_free) begin
					emit = 1'b1;
					if (res.last) begin
						state_d = psb_pkg::S_IDLE;
					end else begin
						idx_d   = idx_q + AW'(1);
						state_d = psb_pkg::S_DUMP_RD;
					end
				end
			end

			psb_pkg::S_STATUS: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = psb_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = psb_pkg::S_IDLE;
			end
		endcase
	end

endmodule
